/* hdl/padt_pkg.sv */
package padt_pkg;

	localparam int ADDR_W = 48;
	localparam int LEN_W  = 19;
	localparam int CMD_W  = 2;
	localparam int RC_W   = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_PROTECT = 2'd0,
		CMD_FAULT   = 2'd1,
		CMD_COLLECT = 2'd2,
		CMD_UNUSED  = 2'd3
	} cmd_t;

	typedef enum logic [RC_W-1:0] {
		RC_PROTECTED    = 3'd0,
		RC_OUT_OF_RANGE = 3'd1,
		RC_NOT_OURS     = 3'd2,
		RC_FETCH        = 3'd3,
		RC_DIRTY_MARKED = 3'd4,
		RC_NO_ACTION    = 3'd5,
		RC_DIRTY_PAGE   = 3'd6,
		RC_NONE_DIRTY   = 3'd7
	} rc_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_WALK,
		ST_FINISH
	} state_t;

	localparam logic [1:0] ACC_NONE = 2'd0;
	localparam logic [1:0] ACC_RO   = 2'd1;
	localparam logic [1:0] ACC_RW   = 2'd2;

	localparam logic REG_BASE = 1'b0;
	localparam logic REG_SIZE = 1'b1;

	typedef struct packed {
		logic       dirty;
		logic [1:0] access;
	} page_t;

	localparam int PAGE_W = $bits(page_t);

endpackage

/* hdl/page_access_dirty_tracker.sv */
// Page access and dirty tracker. An item is taken when start is high and busy is low;
// results come one per strobe cycle on result_code/page_address/last and cannot be
// held off, so the receiver must take them as they appear. Page state sits in one
// RAM of PAGE_COUNT entries with registered read; one page is read and written back
// per cycle. A fault, range error or code error is checked and answered; a protect
// walks the pages touched, a collect walks the configured region (if not empty). The
// next item may start in the cycle the final result is shown. No clearing pass is
// needed after reset. Configuration writes are always ready and must only be
// issued while busy is low and no result is pending.
module page_access_dirty_tracker #(
	parameter int PAGE_COUNT = 64,
	parameter int PAGE_SHIFT = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [padt_pkg::CMD_W-1:0]   command,
	input  logic [padt_pkg::ADDR_W-1:0]  address,
	input  logic [padt_pkg::LEN_W-1:0]   length,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic                         cfg_index,
	input  logic [padt_pkg::ADDR_W-1:0]  cfg_data,
	output logic                         result_strobe,
	output logic [padt_pkg::RC_W-1:0]    result_code,
	output logic [padt_pkg::ADDR_W-1:0]  page_address,
	output logic                         last
);

	import padt_pkg::*;

	localparam int IW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

	logic [ADDR_W-1:0] base;
	logic [ADDR_W:0]   limit;
	logic [IW:0]       page_total;
	logic              ram_we;
	logic [IW-1:0]     ram_waddr;
	page_t             ram_wdata;
	logic              ram_re;
	logic [IW-1:0]     ram_raddr;
	page_t             ram_rdata;

	assign cfg_ready = 1'b1;

	padt_cfg #(
		.PAGE_COUNT(PAGE_COUNT),
		.PAGE_SHIFT(PAGE_SHIFT)
	) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.base       (base),
		.limit      (limit),
		.page_total (page_total)
	);

	padt_ram #(
		.WIDTH(PAGE_W),
		.DEPTH(PAGE_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	padt_ctrl #(
		.PAGE_COUNT(PAGE_COUNT),
		.PAGE_SHIFT(PAGE_SHIFT)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.command       (command),
		.address       (address),
		.length        (length),
		.base          (base),
		.limit         (limit),
		.page_total    (page_total),
		.ram_we        (ram_we),
		.ram_waddr     (ram_waddr),
		.ram_wdata     (ram_wdata),
		.ram_re        (ram_re),
		.ram_raddr     (ram_raddr),
		.ram_rdata     (ram_rdata),
		.result_strobe (result_strobe),
		.result_code   (result_code),
		.page_address  (page_address),
		.last          (last)
	);

endmodule

/* hdl/padt_ram.sv */
module padt_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* hdl/padt_cfg.sv */
module padt_cfg #(
	parameter int PAGE_COUNT = 64,
	parameter int PAGE_SHIFT = 12,
	localparam int IW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_valid,
	input  logic                         cfg_ready,
	input  logic                         cfg_index,
	input  logic [padt_pkg::ADDR_W-1:0]  cfg_data,
	output logic [padt_pkg::ADDR_W-1:0]  base,
	output logic [padt_pkg::ADDR_W:0]    limit,
	output logic [IW:0]                  page_total
);

	import padt_pkg::*;

	localparam int EW = (IW + PAGE_SHIFT + 1 > LEN_W) ? IW + PAGE_SHIFT + 1 : LEN_W;
	localparam logic [EW-1:0] CAP = EW'(PAGE_COUNT) << PAGE_SHIFT;
	localparam logic [EW-1:0] PAGE_MASK = (EW'(1) << PAGE_SHIFT) - EW'(1);

	logic [ADDR_W-1:0] base_q;
	logic [LEN_W-1:0]  size_q;
	logic [EW-1:0]     size_eff;
	logic [EW-1:0]     size_up;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			size_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_BASE) begin
				base_q <= cfg_data;
			end else begin
				size_q <= cfg_data[LEN_W-1:0];
			end
		end
	end

	assign base       = (base_q >> PAGE_SHIFT) << PAGE_SHIFT;
	assign size_eff   = (EW'(size_q) < CAP) ? EW'(size_q) : CAP;
	assign limit      = {1'b0, base} + (ADDR_W+1)'(size_eff);
	assign size_up    = size_eff + PAGE_MASK;
	assign page_total = size_up[PAGE_SHIFT +: IW+1];

endmodule

/* hdl/padt_ctrl.sv */
module padt_ctrl #(
	parameter int PAGE_COUNT = 64,
	parameter int PAGE_SHIFT = 12,
	localparam int IW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [padt_pkg::CMD_W-1:0]   command,
	input  logic [padt_pkg::ADDR_W-1:0]  address,
	input  logic [padt_pkg::LEN_W-1:0]   length,
	input  logic [padt_pkg::ADDR_W-1:0]  base,
	input  logic [padt_pkg::ADDR_W:0]    limit,
	input  logic [IW:0]                  page_total,
	output logic                         ram_we,
	output logic [IW-1:0]                ram_waddr,
	output padt_pkg::page_t              ram_wdata,
	output logic                         ram_re,
	output logic [IW-1:0]                ram_raddr,
	input  padt_pkg::page_t              ram_rdata,
	output logic                         result_strobe,
	output logic [padt_pkg::RC_W-1:0]    result_code,
	output logic [padt_pkg::ADDR_W-1:0]  page_address,
	output logic                         last
);

	import padt_pkg::*;

	state_t            state_q, state_d;
	cmd_t              cmd_q;
	logic [ADDR_W-1:0] addr_q;
	logic [LEN_W-1:0]  len_q;
	logic [IW-1:0]     ptr_q;
	logic [IW-1:0]     end_q;
	logic [IW-1:0]     pend_idx_q;
	logic              pend_vld_q;
	logic [PAGE_COUNT-1:0] vld_q;

	logic              strobe_q;
	rc_t               code_q;
	logic [ADDR_W-1:0] paddr_q;
	logic              last_q;

	logic [ADDR_W:0]   end_addr;
	logic [ADDR_W-1:0] offset;
	logic [ADDR_W:0]   off_last;
	logic              lo_bad;
	logic              prot_bad;
	logic              fault_bad;
	logic [IW-1:0]     first_idx;
	logic [IW-1:0]     last_idx;
	logic              ptr_end;
	page_t             word;

	logic              emit;
	rc_t               emit_code;
	logic              emit_last;
	logic              emit_addr;
	logic [IW-1:0]     addr_idx;
	logic              take_pend;
	logic [ADDR_W-1:0] rep_addr;

	assign end_addr  = {1'b0, addr_q} + (ADDR_W+1)'(len_q);
	assign lo_bad    = addr_q < base;
	assign prot_bad  = lo_bad || (end_addr > limit);
	assign fault_bad = lo_bad || ({1'b0, addr_q} >= limit);
	assign offset    = addr_q - base;
	assign off_last  = end_addr - (ADDR_W+1)'(1) - {1'b0, base};
	assign first_idx = offset[PAGE_SHIFT +: IW];
	assign last_idx  = off_last[PAGE_SHIFT +: IW];
	assign ptr_end   = ptr_q == end_q;
	assign word      = vld_q[ptr_q] ? ram_rdata : page_t'('0);
	assign rep_addr  = base + (ADDR_W'(addr_idx) << PAGE_SHIFT);
	assign busy      = state_q != ST_IDLE;
	assign ram_waddr = ptr_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				case (cmd_q)
					CMD_PROTECT: state_d = (prot_bad || len_q == '0) ? ST_IDLE : ST_WALK;
					CMD_FAULT:   state_d = fault_bad ? ST_IDLE : ST_WALK;
					CMD_COLLECT: state_d = (page_total == '0) ? ST_IDLE : ST_WALK;
					default:     state_d = ST_IDLE;
				endcase
			end
			ST_WALK: begin
				if (ptr_end) begin
					state_d = (cmd_q == CMD_COLLECT) ? ST_FINISH : ST_IDLE;
				end
			end
			ST_FINISH: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		emit      = 1'b0;
		emit_code = RC_NO_ACTION;
		emit_last = 1'b1;
		emit_addr = 1'b0;
		addr_idx  = ptr_q;
		take_pend = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = ptr_q;
		ram_we    = 1'b0;
		ram_wdata = word;
		case (state_q)
			ST_CHECK: begin
				case (cmd_q)
					CMD_PROTECT: begin
						if (prot_bad) begin
							emit      = 1'b1;
							emit_code = RC_OUT_OF_RANGE;
						end else if (len_q == '0) begin
							emit      = 1'b1;
							emit_code = RC_PROTECTED;
						end else begin
							ram_re    = 1'b1;
							ram_raddr = first_idx;
						end
					end
					CMD_FAULT: begin
						if (fault_bad) begin
							emit      = 1'b1;
							emit_code = RC_NOT_OURS;
						end else begin
							ram_re    = 1'b1;
							ram_raddr = first_idx;
						end
					end
					CMD_COLLECT: begin
						if (page_total == '0) begin
							emit      = 1'b1;
							emit_code = RC_NONE_DIRTY;
						end else begin
							ram_re    = 1'b1;
							ram_raddr = '0;
						end
					end
					default: begin
						emit      = 1'b1;
						emit_code = RC_NO_ACTION;
					end
				endcase
			end
			ST_WALK: begin
				if (!ptr_end) begin
					ram_re    = 1'b1;
					ram_raddr = ptr_q + IW'(1);
				end
				case (cmd_q)
					CMD_PROTECT: begin
						ram_we           = 1'b1;
						ram_wdata.access = ACC_RO;
						if (ptr_end) begin
							emit      = 1'b1;
							emit_code = RC_PROTECTED;
						end
					end
					CMD_FAULT: begin
						emit = 1'b1;
						case (word.access)
							ACC_NONE: begin
								ram_we           = 1'b1;
								ram_wdata.access = ACC_RO;
								emit_code        = RC_FETCH;
								emit_addr        = 1'b1;
							end
							ACC_RO: begin
								ram_we           = 1'b1;
								ram_wdata.access = ACC_RW;
								ram_wdata.dirty  = 1'b1;
								emit_code        = RC_DIRTY_MARKED;
							end
							default: emit_code = RC_NO_ACTION;
						endcase
					end
					CMD_COLLECT: begin
						if (word.dirty) begin
							ram_we           = 1'b1;
							ram_wdata.access = ACC_RO;
							ram_wdata.dirty  = 1'b0;
							take_pend        = 1'b1;
							if (pend_vld_q) begin
								emit      = 1'b1;
								emit_code = RC_DIRTY_PAGE;
								emit_addr = 1'b1;
								emit_last = 1'b0;
								addr_idx  = pend_idx_q;
							end
						end
					end
					default: begin
					end
				endcase
			end
			ST_FINISH: begin
				emit     = 1'b1;
				addr_idx = pend_idx_q;
				if (pend_vld_q) begin
					emit_code = RC_DIRTY_PAGE;
					emit_addr = 1'b1;
				end else begin
					emit_code = RC_NONE_DIRTY;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pend_vld_q <= 1'b0;
			vld_q      <= '0;
			strobe_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= emit;
			if (state_q == ST_CHECK) begin
				pend_vld_q <= 1'b0;
			end else if (take_pend) begin
				pend_vld_q <= 1'b1;
			end
			if (ram_we) begin
				vld_q[ptr_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_q  <= cmd_t'(command);
			addr_q <= address;
			len_q  <= length;
		end
		if (state_q == ST_CHECK) begin
			case (cmd_q)
				CMD_PROTECT: begin
					ptr_q <= first_idx;
					end_q <= last_idx;
				end
				CMD_FAULT: begin
					ptr_q <= first_idx;
					end_q <= first_idx;
				end
				default: begin
					ptr_q <= '0;
					end_q <= IW'(page_total - (IW+1)'(1));
				end
			endcase
		end else if (state_q == ST_WALK && !ptr_end) begin
			ptr_q <= ptr_q + IW'(1);
		end
		if (take_pend) begin
			pend_idx_q <= ptr_q;
		end
		if (emit) begin
			code_q  <= emit_code;
			paddr_q <= emit_addr ? rep_addr : '0;
			last_q  <= emit_last;
		end
	end

	assign result_strobe = strobe_q;
	assign result_code   = code_q;
	assign page_address  = paddr_q;
	assign last          = last_q;

	a_no_rw_collide: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_raddr != ram_waddr))
		else $error("read and write hit the same page in one cycle");

	a_walk_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |-> (ptr_q <= end_q))
		else $error("walk pointer passed the last page");

	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && last_q) |=> !strobe_q)
		else $error("result right after the final result of an item");

	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && code_q != RC_FETCH && code_q != RC_DIRTY_PAGE) |-> (paddr_q == '0))
		else $error("page address not zero for a code without address");

	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == ST_CHECK))
		else $error("accepted item did not enter range check");

endmodule
